// File: sv/per_source_kway_merge_reorder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-source k-way merge reorder block
// Concurrent checks clocked on clk_i and disabled during rst_ni; empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_KWAY_MERGE_REORDER_DEFINES_SVH
`define PER_SOURCE_KWAY_MERGE_REORDER_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold on every clock edge
`define PSKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition that implies another in the next cycle
`define PSKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSKM_ASSERT(lbl, prop, msg)
`define PSKM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/pskm_pkg.sv
// ----------------------------------------------------------------------------
// pskm_pkg
// Shared types and constants of the per-source k-way merge reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package pskm_pkg;

  localparam int unsigned SRC_W   = 2;
  localparam int unsigned CYCLE_W = 63;
  localparam int unsigned PAY_W   = 64;

  // config register
  localparam int unsigned NS_W                = 3;
  localparam logic [NS_W-1:0] NS_RESET        = 3'd4;
  localparam int unsigned APB_AW              = 3;
  localparam int unsigned APB_DW              = 32;
  localparam int unsigned REG_IDX_W           = 1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_SOURCES = 1'b0;

  typedef enum logic [1:0] {
    ST_EMIT  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic               end_of_input;
    logic [SRC_W-1:0]   source_id;
    logic [CYCLE_W-1:0] req_cycle;
    logic [PAY_W-1:0]   payload;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [SRC_W-1:0]   source_id_res;
    logic [CYCLE_W-1:0] req_cycle_res;
    logic [PAY_W-1:0]   payload_res;
    logic               last;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               drain;
    logic               bad_src;
    logic [SRC_W-1:0]   source_id;
    logic [CYCLE_W-1:0] req_cycle;
    logic [PAY_W-1:0]   payload;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/per_source_kway_merge_reorder.sv
// ----------------------------------------------------------------------------
// per_source_kway_merge_reorder
// Reorders per-source trace records into one stream sorted by request cycle.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one record or a drain
//   marker per word. Words land in a two-entry command queue, so the input
//   can run up to two words ahead while the merge engine works or the output is stalled.
// Output channel (out_valid_o / out_stall_i / out_word_o): zero or more result
//   words per input word; the final one carries last. A record that causes no
//   merge produces no word at all.
// Config: APB-style, one register (num_sources) at byte 0; pready is tied high.
// Timing: the FIFO heads sit in a single RAM and are scanned one per cycle through
//   its registered read port, then the winner is handed to the output register.
// Reset: all FIFOs empty, num_sources = 4, both channels idle. The RAM is not
//   cleared; fill counts keep unwritten entries from being read.
// Stall: while out_stall_i is high the output word holds; the engine waits with
//   its next result, the queue fills, and then in_stall_o goes high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_source_kway_merge_reorder_defines.svh"

module per_source_kway_merge_reorder import pskm_pkg::*; #(
  parameter int MAX_SOURCES   = 4,
  parameter int FIFO_DEPTH    = 16,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // record input
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_word_t          in_word_i,
  // result output
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_word_o,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int NW = $clog2(MAX_SOURCES + 1);

  logic [NS_W-1:0]      num_sources_q, num_sources_d;
  logic [NW-1:0]        n_eff;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 cmd_valid;
  logic                 cmd_pop;
  cmd_t                 cmd;
  logic                 back_idle;

  // --- register port ---------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    num_sources_d = num_sources_q;
    if (cfg_wr && (reg_idx == REG_NUM_SOURCES)) begin
      num_sources_d = pwdata[NS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_NUM_SOURCES) begin
      prdata = APB_DW'(num_sources_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sources_q <= NS_RESET;
    end else begin
      num_sources_q <= num_sources_d;
    end
  end

  // zero counts as one source, large values clamp to what is built
  always_comb begin
    if (num_sources_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_sources_q) > MAX_SOURCES) begin
      n_eff = NW'(MAX_SOURCES);
    end else begin
      n_eff = NW'(num_sources_q);
    end
  end

  // --- front: accept, classify, queue -----------------------------------------
  pskm_front #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_eff_i     (n_eff),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // --- back: FIFOs, minimum scan, output register -----------------------------
  pskm_back #(
    .MAX_SOURCES   (MAX_SOURCES),
    .FIFO_DEPTH    (FIFO_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_eff_i     (n_eff),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .idle_o      (back_idle),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // --- checks ------------------------------------------------------------------
  // a rejection is always a single, final word
  `PSKM_ASSERT(a_reject_last, (out_valid_o && out_word_o.status != ST_EMIT) |-> out_word_o.last, "reject without last")
  // a full queue only frees up when the engine takes a command
  `PSKM_ASSERT_NEXT(a_queue_holds, in_stall_o && !cmd_pop, in_stall_o, "queue freed without pop")
  // taking a command always starts engine work
  `PSKM_ASSERT_NEXT(a_pop_busy, cmd_pop, !back_idle, "engine idle after pop")

endmodule

`default_nettype wire

// File: sv/pskm_ram.sv
// ----------------------------------------------------------------------------
// pskm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pskm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/pskm_front.sv
// ----------------------------------------------------------------------------
// pskm_front
// Input side: takes words, tags drains and out-of-range sources, and
// holds them in a two-entry command queue for the merge engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pskm_front import pskm_pkg::*; #(
  parameter int MAX_SOURCES = 4,
  localparam int NW = $clog2(MAX_SOURCES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [NW-1:0] n_eff_i,
  input  wire logic          in_valid_i,
  input  wire in_word_t      in_word_i,
  output logic               in_stall_o,
  output logic               cmd_valid_o,
  output cmd_t               cmd_o,
  input  wire logic          cmd_pop_i
);

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  cmd_t             q_q [QDEPTH];
  logic [QPW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             push;
  cmd_t             cmd_new;

  assign in_stall_o  = (cnt_q == QCW'(QDEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rptr_q];

  always_comb begin
    cmd_new.drain     = in_word_i.end_of_input;
    cmd_new.bad_src   = !in_word_i.end_of_input &&
                        (32'(in_word_i.source_id) >= 32'(n_eff_i));
    cmd_new.source_id = in_word_i.source_id;
    cmd_new.req_cycle = in_word_i.req_cycle;
    cmd_new.payload   = in_word_i.payload;
  end

  always_comb begin
    wptr_d = push ? wptr_q + QPW'(1) : wptr_q;
    rptr_d = cmd_pop_i ? rptr_q + QPW'(1) : rptr_q;
    cnt_d  = cnt_q + QCW'(push) - QCW'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

// File: sv/pskm_back.sv
// ----------------------------------------------------------------------------
// pskm_back
// Merge engine: per-source FIFOs in one RAM, a serial head scan for the
// minimum cycle, pop bookkeeping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pskm_back import pskm_pkg::*; #(
  parameter int MAX_SOURCES   = 4,
  parameter int FIFO_DEPTH    = 16,
  parameter int PAYLOAD_WIDTH = 64,
  localparam int NW = $clog2(MAX_SOURCES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [NW-1:0] n_eff_i,
  input  wire logic          cmd_valid_i,
  input  wire cmd_t          cmd_i,
  output logic               cmd_pop_o,
  output logic               idle_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output out_word_t          out_word_o
);

  localparam int SIW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int SCW   = $clog2(MAX_SOURCES + 1);
  localparam int PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW    = $clog2(FIFO_DEPTH + 1);
  localparam int DEPTH = MAX_SOURCES * FIFO_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = CYCLE_W + PAYLOAD_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } back_state_e;

  back_state_e              state_q, state_d;
  logic [CW-1:0]            fill_q [MAX_SOURCES];
  logic [CW-1:0]            fill_d [MAX_SOURCES];
  logic [PW-1:0]            rp_q [MAX_SOURCES];
  logic [PW-1:0]            rp_d [MAX_SOURCES];
  logic [PW-1:0]            wp_q [MAX_SOURCES];
  logic [PW-1:0]            wp_d [MAX_SOURCES];
  logic                     drain_q, drain_d;
  logic [SCW-1:0]           iss_q, iss_d;
  logic                     pend_q, pend_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [SIW-1:0]           rd_src_q, rd_src_d;
  logic                     found_q, found_d;
  logic [SIW-1:0]           best_src_q, best_src_d;
  logic [CYCLE_W-1:0]       best_cyc_q, best_cyc_d;
  logic [PAYLOAD_WIDTH-1:0] best_pay_q, best_pay_d;
  out_word_t                res_q, res_d, out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  logic [MAX_SOURCES-1:0]   fill_nz, need_v, best_oh;
  logic                     all_ready, any_fill, other_nz, one_left, last_pop;
  logic [SIW-1:0]           src_idx, iss_idx;
  logic                     issuing, take;
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [DW-1:0]            wdata, rdata;
  logic [CYCLE_W-1:0]       rd_cyc;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  pskm_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-source flags
  always_comb begin
    for (int s = 0; s < MAX_SOURCES; s++) begin
      fill_nz[s] = (fill_q[s] != '0);
      need_v[s]  = (32'(n_eff_i) > s);
      best_oh[s] = (best_src_q == SIW'(s));
    end
  end

  assign all_ready = &(fill_nz | ~need_v);
  assign any_fill  = |fill_nz;
  assign other_nz  = |(fill_nz & ~best_oh);
  assign one_left  = (fill_q[best_src_q] == CW'(1));
  // would the merge stop after popping the current winner
  assign last_pop  = drain_q ? (!other_nz && one_left) : ((|(need_v & best_oh)) && one_left);

  assign src_idx = SIW'(cmd_i.source_id);
  assign iss_idx = iss_q[SIW-1:0];
  assign issuing = (state_q == S_SCAN) && (iss_q < SCW'(MAX_SOURCES));

  assign raddr  = AW'(32'(iss_idx) * FIFO_DEPTH + 32'(rp_q[iss_idx]));
  assign waddr  = AW'(32'(src_idx) * FIFO_DEPTH + 32'(wp_q[src_idx]));
  assign wdata  = {cmd_i.req_cycle, cmd_i.payload[PAYLOAD_WIDTH-1:0]};
  assign rd_cyc = rdata[DW-1:PAYLOAD_WIDTH];
  assign rd_pay = rdata[PAYLOAD_WIDTH-1:0];
  // ties go to the later (higher) source
  assign take   = pend_q && rd_vld_q && (!found_q || (rd_cyc <= best_cyc_q));

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    drain_d     = drain_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    rd_vld_d    = 1'b0;
    rd_src_d    = iss_idx;
    found_d     = found_q;
    best_src_d  = best_src_q;
    best_cyc_d  = best_cyc_q;
    best_pay_d  = best_pay_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          drain_d = cmd_i.drain;
          if (cmd_i.drain) begin
            state_d = S_CHECK;
          end else if (cmd_i.bad_src || (fill_q[src_idx] == CW'(FIFO_DEPTH))) begin
            res_d = '{status:        cmd_i.bad_src ? ST_RANGE : ST_FULL,
                      source_id_res: cmd_i.source_id,
                      req_cycle_res: cmd_i.req_cycle,
                      payload_res:   PAY_W'(cmd_i.payload[PAYLOAD_WIDTH-1:0]),
                      last:          1'b1};
            state_d = S_EMIT;
          end else begin
            we               = 1'b1;
            wp_d[src_idx]    = (wp_q[src_idx] == PW'(FIFO_DEPTH - 1)) ? '0
                                                                      : wp_q[src_idx] + PW'(1);
            fill_d[src_idx]  = fill_q[src_idx] + CW'(1);
            state_d          = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (drain_q ? any_fill : all_ready) begin
          iss_d   = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        // issue one head read per cycle, compare when its data returns in the next cycle
        if (issuing) begin
          iss_d    = iss_q + SCW'(1);
          pend_d   = 1'b1;
          rd_vld_d = fill_nz[iss_idx];
        end
        if (take) begin
          found_d    = 1'b1;
          best_src_d = rd_src_q;
          best_cyc_d = rd_cyc;
          best_pay_d = rd_pay;
        end
        if (!issuing && !pend_q) begin
          rp_d[best_src_q]   = (rp_q[best_src_q] == PW'(FIFO_DEPTH - 1)) ? '0
                                                                         : rp_q[best_src_q] + PW'(1);
          fill_d[best_src_q] = fill_q[best_src_q] - CW'(1);
          res_d = '{status:        ST_EMIT,
                    source_id_res: SRC_W'(best_src_q),
                    req_cycle_res: best_cyc_q,
                    payload_res:   PAY_W'(best_pay_q),
                    last:          last_pop};
          state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          if (res_q.last) begin
            state_d = S_IDLE;
          end else begin
            iss_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int s = 0; s < MAX_SOURCES; s++) begin
        fill_q[s] <= '0;
        rp_q[s]   <= '0;
        wp_q[s]   <= '0;
      end
      drain_q     <= 1'b0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_src_q    <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      drain_q     <= drain_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      rd_vld_q    <= rd_vld_d;
      rd_src_q    <= rd_src_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_src_q <= best_src_d;
    best_cyc_q <= best_cyc_d;
    best_pay_q <= best_pay_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire
